// ===== rtl/core/ssnfb_pkg.sv =====
// Shared types, constants and lookup functions of the seven-segment frame builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ssnfb_pkg;

	localparam int DIGITS    = 6;
	localparam int MAG_W     = 24;
	localparam int DEC_W     = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	localparam logic [1:0] REQ_DEC   = 2'd0;
	localparam logic [1:0] REQ_HEX   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 1'b1;

	localparam logic [2:0] BRIGHTNESS_RST = 3'd2;
	localparam logic [7:0] START_ADDR_RST = 8'hC0;

	localparam logic [7:0] CMD_AUTO_INC  = 8'h40;
	localparam logic [7:0] CMD_DISP_CTRL = 8'h88;
	localparam logic [7:0] SEG_DP        = 8'h80;
	localparam logic [7:0] SEG_MINUS     = 8'h40;
	localparam logic [7:0] SEG_BLANK     = 8'h00;

	// Byte positions within the nine-byte frame
	localparam logic [3:0] BYTE_CMD       = 4'd0;
	localparam logic [3:0] BYTE_ADDR      = 4'd1;
	localparam logic [3:0] BYTE_SEG_FIRST = 4'd2;
	localparam logic [3:0] BYTE_SEG_LAST  = 4'd7;
	localparam logic [3:0] BYTE_CTRL      = 4'd8;

	localparam logic signed [32:0] DEC_MAX = 33'sd999999;
	localparam logic signed [32:0] DEC_MIN = -33'sd99999;

	// Reciprocals for exact division of small values: x / d == (x * R) >> k
	localparam logic [20:0] RECIP_1000 = 21'd1073742; // k = 30, x < 2^20
	localparam logic [12:0] RECIP_10   = 13'd6554;    // k = 16, x < 1000
	localparam logic [9:0]  RECIP_100  = 10'd656;     // k = 16, x < 1000

	typedef logic [7:0] seg_t;
	typedef seg_t [DIGITS-1:0] seg_row_t;

	typedef struct packed {
		logic     valid;
		seg_row_t seg;
	} seg_frame_t;

	function automatic seg_t seg_font(input logic [3:0] d);
		seg_t s;
		unique case (d)
			4'h0: s = 8'h3F;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5B;
			4'h3: s = 8'h4F;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6D;
			4'h6: s = 8'h7D;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h6F;
			4'hA: s = 8'h77;
			4'hB: s = 8'h7C;
			4'hC: s = 8'h39;
			4'hD: s = 8'h5E;
			4'hE: s = 8'h79;
			4'hF: s = 8'h71;
		endcase
		return s;
	endfunction

	// Digit sent in each of the six segment slots
	function automatic logic [2:0] send_digit(input logic [2:0] slot);
		logic [2:0] d;
		unique case (slot)
			3'd0:    d = 3'd3;
			3'd1:    d = 3'd4;
			3'd2:    d = 3'd5;
			3'd3:    d = 3'd0;
			3'd4:    d = 3'd1;
			3'd5:    d = 3'd2;
			default: d = 3'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssnfb_if.sv =====
// Channel interfaces of the frame builder: request, frame byte and config write.
// Depends on ssnfb_pkg for the config index and data widths.
`default_nettype none

interface ssnfb_req_if ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic signed [32:0] value;
	logic              show_zeros;
	logic [3:0]        dp_position;

	modport source (output valid, req_type, value, show_zeros, dp_position, input ready);
	modport sink   (input valid, req_type, value, show_zeros, dp_position, output ready);
endinterface

interface ssnfb_byte_if ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;
	logic       frame_end;
	logic       last;

	modport source (output valid, data_byte, frame_start, frame_end, last, input ready);
	modport sink   (input valid, data_byte, frame_start, frame_end, last, output ready);
endinterface

interface ssnfb_cfg_if import ssnfb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ssnfb_digit_pipe.sv =====
// Six-stage pipeline from request to the six segment bytes of a frame.
// Depends on ssnfb_pkg and the request interface in ssnfb_if.sv.
`default_nettype none

module ssnfb_digit_pipe import ssnfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ssnfb_req_if.sink    req,
	input  logic         take,
	output seg_frame_t   frame
);

	typedef struct packed {
		logic       is_num;
		logic       is_err;
		logic       is_hex;
		logic       neg;
		logic       lz;
		logic [3:0] dp;
	} ctl_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [MAG_W-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [9:0] q_s2, hi_s3, lo_s3, hi_s4, lo_s4;
	logic [6:0] thi_s4, tlo_s4;
	logic [3:0] hhi_s4, hlo_s4;
	logic [DIGITS-1:0][3:0] dig_s5;
	seg_row_t seg_s6;

	// Advance a stage when it is empty or its successor advances
	assign rdy_s6 = !v_s6 || take;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: classify, range check, magnitude
	logic [32:0] raw;
	logic [32:0] abs_val;
	logic        is_dec, is_hex, dec_err, hex_err;
	ctl_t        ctl_in;
	logic [MAG_W-1:0] mag_in;

	always_comb begin
		raw     = req.value;
		abs_val = raw[32] ? (~raw + 33'd1) : raw;
		is_dec  = (req.req_type == REQ_DEC);
		is_hex  = (req.req_type == REQ_HEX);
		dec_err = (req.value > DEC_MAX) || (req.value < DEC_MIN);
		hex_err = |raw[32:MAG_W];
		ctl_in.is_num = (is_dec && !dec_err) || (is_hex && !hex_err);
		ctl_in.is_err = (is_dec && dec_err) || (is_hex && hex_err);
		ctl_in.is_hex = is_hex;
		ctl_in.neg    = is_dec && raw[32];
		ctl_in.lz     = req.show_zeros;
		ctl_in.dp     = req.dp_position;
		mag_in = is_hex ? raw[MAG_W-1:0] : {{(MAG_W-DEC_W){1'b0}}, abs_val[DEC_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ctl_s1 <= ctl_in;
			mag_s1 <= mag_in;
		end
	end

	// Stage 2: upper three decimal digits as magnitude / 1000
	logic [40:0] prod_k;
	assign prod_k = 41'(mag_s1[DEC_W-1:0]) * 41'(RECIP_1000);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ctl_s2 <= ctl_s1;
			mag_s2 <= mag_s1;
			q_s2   <= prod_k[39:30];
		end
	end

	// Stage 3: lower three decimal digits as the remainder
	logic [DEC_W-1:0] q_times, lo_full;
	assign q_times = 20'(q_s2) * 20'd1000;
	assign lo_full = mag_s2[DEC_W-1:0] - q_times;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ctl_s3 <= ctl_s2;
			mag_s3 <= mag_s2;
			hi_s3  <= q_s2;
			lo_s3  <= lo_full[9:0];
		end
	end

	// Stage 4: tens and hundreds quotients of each three-digit half
	logic [22:0] p10_hi, p10_lo;
	logic [19:0] p100_hi, p100_lo;
	assign p10_hi  = 23'(hi_s3) * 23'(RECIP_10);
	assign p10_lo  = 23'(lo_s3) * 23'(RECIP_10);
	assign p100_hi = 20'(hi_s3) * 20'(RECIP_100);
	assign p100_lo = 20'(lo_s3) * 20'(RECIP_100);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			ctl_s4 <= ctl_s3;
			mag_s4 <= mag_s3;
			hi_s4  <= hi_s3;
			lo_s4  <= lo_s3;
			thi_s4 <= p10_hi[22:16];
			tlo_s4 <= p10_lo[22:16];
			hhi_s4 <= p100_hi[19:16];
			hlo_s4 <= p100_lo[19:16];
		end
	end

	// Stage 5: digit values, decimal or hex nibbles
	logic [DIGITS-1:0][3:0] dig_in;
	logic [9:0] d0_lo, d1_lo, d0_hi, d1_hi;

	always_comb begin
		d0_lo = lo_s4 - 10'(tlo_s4) * 10'd10;
		d1_lo = 10'(tlo_s4) - 10'(hlo_s4) * 10'd10;
		d0_hi = hi_s4 - 10'(thi_s4) * 10'd10;
		d1_hi = 10'(thi_s4) - 10'(hhi_s4) * 10'd10;
		if (ctl_s4.is_hex) begin
			for (int i = 0; i < DIGITS; i++) begin
				dig_in[i] = mag_s4[4*i +: 4];
			end
		end else begin
			dig_in[0] = d0_lo[3:0];
			dig_in[1] = d1_lo[3:0];
			dig_in[2] = hlo_s4;
			dig_in[3] = d0_hi[3:0];
			dig_in[4] = d1_hi[3:0];
			dig_in[5] = hhi_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			ctl_s5 <= ctl_s4;
			dig_s5 <= dig_in;
		end
	end

	// Stage 6: font, blanking, minus, dashes, decimal point
	seg_row_t          seg_in;
	logic [DIGITS-1:0] zero_up;
	logic              dp_hit;
	logic [2:0]        dp_idx;

	always_comb begin
		zero_up[DIGITS-1] = (dig_s5[DIGITS-1] == 4'd0);
		for (int i = DIGITS - 2; i >= 0; i--) begin
			zero_up[i] = zero_up[i+1] && (dig_s5[i] == 4'd0);
		end
		dp_hit = !ctl_s5.dp[3] && (ctl_s5.dp[2:0] < 3'(DIGITS));
		dp_idx = 3'(3'(DIGITS - 1) - ctl_s5.dp[2:0]);
		for (int i = 0; i < DIGITS; i++) begin
			if (ctl_s5.is_err) begin
				seg_in[i] = SEG_MINUS;
			end else if (!ctl_s5.is_num) begin
				seg_in[i] = SEG_BLANK;
			end else begin
				if (i > 0 && !ctl_s5.lz && zero_up[i]) seg_in[i] = SEG_BLANK;
				else                                    seg_in[i] = seg_font(dig_s5[i]);
				if (i == DIGITS - 1 && ctl_s5.neg)      seg_in[i] = SEG_MINUS;
				if (dp_hit && dp_idx == 3'(i))          seg_in[i] = seg_in[i] | SEG_DP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			seg_s6 <= seg_in;
		end
	end

	assign frame.valid = v_s6;
	assign frame.seg   = seg_s6;

endmodule

`default_nettype wire

// ===== rtl/core/seven_segment_number_frame_builder.sv =====
// Top level of the seven-segment number frame builder: config registers,
// frame serializer and output register. Depends on ssnfb_pkg, ssnfb_if.sv, ssnfb_digit_pipe.
`default_nettype none

//  channel  modport  payload                                          role
//  req      sink     req_type, value, show_zeros, dp_position         one request per transfer
//  frame    source   data_byte, frame_start, frame_end, last          nine transfers per request
//  cfg      sink     index, data                                      register write, always ready
//
//  A request passes six pipeline stages, then the serializer, then the output
//  register before its first byte is offered on frame. The serializer sends one
//  byte per cycle while frame is not stalled, nine bytes per request; the next
//  frame's first byte follows the last byte with no gap.
//  Reset returns brightness to 2 and start_address to 0xC0; there is no clearing pass.
//  Backpressure on frame holds the output register, the serializer and then the
//  pipeline stage by stage; nothing is dropped or repeated.

module seven_segment_number_frame_builder import ssnfb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ssnfb_req_if.sink     req,
	ssnfb_byte_if.source  frame,
	ssnfb_cfg_if.sink     cfg
);

	// Configuration registers
	logic [2:0] brightness_q;
	logic [7:0] start_addr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_RST;
			start_addr_q <= START_ADDR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BRIGHTNESS: brightness_q <= cfg.data[2:0];
				CFG_START_ADDR: start_addr_q <= cfg.data;
			endcase
		end
	end

	// Segment pipeline
	seg_frame_t pipe_frame;
	logic       ser_take;

	ssnfb_digit_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (ser_take),
		.frame  (pipe_frame)
	);

	// Serializer: hold one frame, step a byte counter through it
	logic       frame_v_q;
	logic [3:0] cnt_q;
	seg_row_t   seg_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_start_q, out_end_q, out_last_q;

	logic       out_load;
	logic       emit;
	logic       last_emit;

	assign out_load  = !out_v_q || frame.ready;
	assign emit      = frame_v_q && out_load;
	assign last_emit = emit && (cnt_q == BYTE_CTRL);
	// Take the next frame when idle, or while the current one hands over its final byte
	assign ser_take  = !frame_v_q || last_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_v_q <= 1'b0;
			cnt_q     <= BYTE_CMD;
		end else if (ser_take && pipe_frame.valid) begin
			frame_v_q <= 1'b1;
			cnt_q     <= BYTE_CMD;
		end else if (last_emit) begin
			frame_v_q <= 1'b0;
		end else if (emit) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take && pipe_frame.valid) seg_q <= pipe_frame.seg;
	end

	// Byte and framing flags for the current counter value
	logic [3:0] slot_full;
	logic [7:0] next_byte;
	logic       next_start, next_end, next_last;

	always_comb begin
		slot_full  = cnt_q - BYTE_SEG_FIRST;
		next_start = 1'b0;
		next_end   = 1'b0;
		next_last  = 1'b0;
		unique case (cnt_q)
			BYTE_CMD: begin
				next_byte  = CMD_AUTO_INC;
				next_start = 1'b1;
				next_end   = 1'b1;
			end
			BYTE_ADDR: begin
				next_byte  = start_addr_q;
				next_start = 1'b1;
			end
			BYTE_CTRL: begin
				next_byte  = CMD_DISP_CTRL + 8'(brightness_q);
				next_start = 1'b1;
				next_end   = 1'b1;
				next_last  = 1'b1;
			end
			default: begin
				next_byte = seg_q[send_digit(slot_full[2:0])];
				next_end  = (cnt_q == BYTE_SEG_LAST);
			end
		endcase
	end

	// Output register: parts the serializer from the frame sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= frame_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= next_byte;
			out_start_q <= next_start;
			out_end_q   <= next_end;
			out_last_q  <= next_last;
		end
	end

	assign frame.valid       = out_v_q;
	assign frame.data_byte   = out_byte_q;
	assign frame.frame_start = out_start_q;
	assign frame.frame_end   = out_end_q;
	assign frame.last        = out_last_q;

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_v_q |-> (cnt_q <= BYTE_CTRL))
		else $error("byte counter beyond frame end");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_v_q && !out_load) |=> (frame_v_q && $stable(cnt_q)))
		else $error("serializer moved while output stalled");

	a_next_frame_head: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && frame.last) |=>
			(!frame.valid || (frame.data_byte == CMD_AUTO_INC && frame.frame_start)))
		else $error("frame does not open with the command byte");

endmodule

`default_nettype wire

// ===== dv/seven_segment_number_frame_builder_tb.sv =====
// Self-checking testbench of the seven-segment number frame builder.
// Depends on ssnfb_pkg, the channel interfaces of ssnfb_if.sv and the block's RTL.
`default_nettype none

module seven_segment_number_frame_builder_tb import ssnfb_pkg::*; ();

	// Display encoding, kept apart from the block's own tables
	localparam logic [7:0] AUTO_INC  = 8'h40;
	localparam logic [7:0] CTRL_BASE = 8'h88;
	localparam logic [7:0] DOT_SEG   = 8'h80;
	localparam logic [7:0] DASH_SEG  = 8'h40;
	localparam logic [7:0] OFF_SEG   = 8'h00;
	localparam logic [15:0][7:0] GLYPH = {
		8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
		8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};
	// Digit carried by each segment slot, listed from slot 5 down to slot 0
	localparam logic [5:0][2:0] SLOT_DIGIT = {3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3};
	localparam int NUM_DIGITS = 6;

	// Request code left unused by the block; it blanks the display like clear
	localparam logic [1:0] REQ_SPARE = 2'd3;

	localparam logic signed [32:0] DEC_TOP    = 33'sd999999;
	localparam logic signed [32:0] DEC_BOTTOM = -33'sd99999;
	localparam logic [32:0]        HEX_TOP    = 33'h0_00FF_FFFF;

	// Idle time after the last owed byte has come out; allow margin
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       frame_end;
		logic       last;
	} frame_byte_t;

	logic clk;
	logic arst_n;

	ssnfb_req_if  req_ch ();
	ssnfb_byte_if frame_ch ();
	ssnfb_cfg_if  cfg_ch ();

	seven_segment_number_frame_builder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	// Bytes still owed by the block, oldest first
	frame_byte_t due_bytes[$];

	// Our copy of the display registers
	logic [2:0] shown_brightness;
	logic [7:0] shown_address;

	// Idling bounds: 0 means no idling on that side, else idling per item is drawn from 0 up to the bound
	int req_gap_max;
	int stall_max;

	int errors;
	int cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[seven_segment_number_frame_builder] ERROR");
			$finish;
		end
	end

	// Work out the nine frame bytes for one request and queue them.
	// Digits are formed least significant first; digit 5 is the leftmost.
	function automatic void predict_frame(input logic [1:0] kind, input logic signed [32:0] num,
			input logic lz, input logic [3:0] dp);
		logic [7:0]  digit [NUM_DIGITS];
		logic [32:0] mag;
		logic [32:0] radix;
		logic [32:0] rem;
		logic        dashes;
		logic        dot_ok;
		logic        neg;
		frame_byte_t fb;
		int          i;

		dashes = 1'b0;
		dot_ok = 1'b0;
		neg    = 1'b0;
		mag    = '0;
		radix  = 33'd10;
		for (i = 0; i < NUM_DIGITS; i++)
			digit[i] = OFF_SEG;

		case (kind)
			REQ_DEC: begin
				if (num > DEC_TOP || num < DEC_BOTTOM) begin
					dashes = 1'b1;
				end else begin
					neg    = (num < 0);
					mag    = neg ? 33'(-num) : 33'(num);
					dot_ok = 1'b1;
				end
			end
			REQ_HEX: begin
				// Negative values are read as their raw pattern and so overflow
				if (33'(num) > HEX_TOP) begin
					dashes = 1'b1;
				end else begin
					mag    = 33'(num);
					radix  = 33'd16;
					dot_ok = 1'b1;
				end
			end
			default: ; // clear and the unused code both blank the display
		endcase

		if (dot_ok) begin
			for (i = 0; i < NUM_DIGITS; i++) begin
				rem = mag % radix;
				mag = mag / radix;
				// Blank leading zeros, but never the rightmost digit
				if (mag == 0 && rem == 0 && !lz && i > 0)
					digit[i] = OFF_SEG;
				else
					digit[i] = GLYPH[rem[3:0]];
			end
			if (neg)
				digit[NUM_DIGITS-1] = DASH_SEG;
		end
		if (dashes)
			for (i = 0; i < NUM_DIGITS; i++)
				digit[i] = DASH_SEG;
		// The point is counted from the left and lands even on blanks and minus
		if (dot_ok && dp < NUM_DIGITS)
			digit[NUM_DIGITS-1-dp] = digit[NUM_DIGITS-1-dp] | DOT_SEG;

		fb = '{AUTO_INC, 1'b1, 1'b1, 1'b0};
		due_bytes.push_back(fb);
		fb = '{shown_address, 1'b1, 1'b0, 1'b0};
		due_bytes.push_back(fb);
		for (i = 0; i < NUM_DIGITS; i++) begin
			fb = '{digit[SLOT_DIGIT[i]], 1'b0, (i == NUM_DIGITS-1), 1'b0};
			due_bytes.push_back(fb);
		end
		fb = '{CTRL_BASE + {5'b0, shown_brightness}, 1'b1, 1'b1, 1'b1};
		due_bytes.push_back(fb);
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Frame side: compare every byte transfer with the oldest owed byte
	always @(posedge clk) begin : check_bytes
		frame_byte_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (due_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte, expected none, actual %0h", $time,
					frame_ch.data_byte);
			end else begin
				want = due_bytes.pop_front();
				check_field("data_byte", want.data_byte, frame_ch.data_byte);
				check_field("frame_start", {7'b0, want.frame_start}, {7'b0, frame_ch.frame_start});
				check_field("frame_end", {7'b0, want.frame_end}, {7'b0, frame_ch.frame_end});
				check_field("last", {7'b0, want.last}, {7'b0, frame_ch.last});
			end
		end
	end

	// Frame side backpressure: draw a stall before each byte, then hold ready
	// high until a transfer happens
	initial begin : byte_sink
		int stall;
		frame_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				frame_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frame_ch.ready <= 1'b1;
			do @(posedge clk); while (!frame_ch.valid);
		end
	end

	// Offer one request after a random gap and hold it until the transfer.
	// Valid stays high afterwards so a gapless next request needs no toggle.
	task automatic send_request(input logic [1:0] kind, input logic signed [32:0] num,
			input logic lz, input logic [3:0] dp);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.value       <= num;
		req_ch.show_zeros  <= lz;
		req_ch.dp_position <= dp;
		do @(posedge clk); while (!req_ch.ready);
		predict_frame(kind, num, lz, dp);
	endtask

	// Drop valid and wait until every owed byte has come out, then settle
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both display registers while the block is idle
	task automatic set_display(input logic [2:0] level, input logic [7:0] addr);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_BRIGHTNESS;
		cfg_ch.data  <= {5'b0, level};
		do @(posedge clk); while (!cfg_ch.ready);
		shown_brightness = level;
		cfg_ch.index <= CFG_START_ADDR;
		cfg_ch.data  <= addr;
		do @(posedge clk); while (!cfg_ch.ready);
		shown_address = addr;
		cfg_ch.valid <= 1'b0;
	endtask

	// Negative number of random magnitude 1..2^31, as a 33-bit pattern
	function automatic logic signed [32:0] big_negative();
		return -$signed({1'b0, 32'($urandom_range(1, 32'h8000_0000))});
	endfunction

	// One random request: mostly well-formed values of every length, with
	// boundaries, overflow, clears and the unused code mixed in
	task automatic send_random_request();
		logic [1:0]         kind;
		logic signed [32:0] num;
		logic [31:0]        mag;
		logic [3:0]         dp;
		int                 pick;
		int                 len;

		pick = $urandom_range(0, 99);
		len  = $urandom_range(1, 6);
		kind = REQ_DEC;
		if (pick < 40) begin
			// in-range decimal, negative ones limited to five digits
			if ($urandom_range(0, 2) == 0) begin
				if (len == 6) len = 5;
				mag = $urandom_range(1, 10 ** len - 1);
				num = -$signed({1'b0, mag});
			end else begin
				mag = $urandom_range(0, 10 ** len - 1);
				num = $signed({1'b0, mag});
			end
		end else if (pick < 45) begin
			case ($urandom_range(0, 3))
				0: num = DEC_TOP;
				1: num = DEC_TOP + 1;
				2: num = DEC_BOTTOM;
				default: num = DEC_BOTTOM - 1;
			endcase
		end else if (pick < 53) begin
			num = $urandom_range(0, 1) ? $signed({1'b0, $urandom}) : big_negative();
		end else if (pick < 83) begin
			kind = REQ_HEX;
			mag  = $urandom_range(0, (1 << (4 * len)) - 1);
			num  = $signed({1'b0, mag});
		end else if (pick < 89) begin
			kind = REQ_HEX;
			num  = $urandom_range(0, 1)
				? $signed({1'b0, 32'($urandom_range(32'h0100_0000, 32'hFFFF_FFFF))})
				: big_negative();
		end else begin
			// clear or the unused code, with junk in the ignored fields
			kind = (pick < 95) ? REQ_CLEAR : REQ_SPARE;
			num  = $urandom_range(0, 1) ? $signed({1'b0, $urandom}) : big_negative();
		end
		dp = $urandom_range(0, 1) ? 4'($urandom_range(0, 6)) : 4'($urandom_range(0, 15));
		send_request(kind, num, 1'($urandom_range(0, 1)), dp);
	endtask

	// Reset values of the registers, field extremes and every special case
	task automatic test_directed();
		send_request(REQ_DEC, 33'sd0, 1'b0, 4'd15);
		send_request(REQ_DEC, 33'sd0, 1'b1, 4'd6);
		send_request(REQ_DEC, DEC_TOP, 1'b0, 4'd0);
		send_request(REQ_DEC, DEC_TOP + 1, 1'b0, 4'd2);       // overflow hides the point
		send_request(REQ_DEC, DEC_BOTTOM, 1'b0, 4'd5);
		send_request(REQ_DEC, DEC_BOTTOM - 1, 1'b1, 4'd1);
		send_request(REQ_DEC, -33'sd1, 1'b1, 4'd3);          // minus over leading zeros
		send_request(REQ_DEC, -33'sd42, 1'b0, 4'd0);         // point on the minus digit
		send_request(REQ_DEC, 33'sd7, 1'b0, 4'd1);           // point on a blank digit
		send_request(REQ_DEC, 33'sd123456, 1'b0, 4'd4);
		send_request(REQ_DEC, 33'sh0_FFFF_FFFF, 1'b1, 4'd3);
		send_request(REQ_DEC, -33'sh0_8000_0000, 1'b0, 4'd3);
		send_request(REQ_HEX, 33'sd0, 1'b0, 4'd9);
		send_request(REQ_HEX, 33'sh0_00FF_FFFF, 1'b0, 4'd5);
		send_request(REQ_HEX, 33'sh0_0100_0000, 1'b0, 4'd0);
		send_request(REQ_HEX, 33'sh0_00AB_CDEF, 1'b1, 4'd7);  // every letter glyph
		send_request(REQ_HEX, 33'sh0_0000_BEEF, 1'b1, 4'd2);
		send_request(REQ_HEX, 33'sh0_0000_000F, 1'b0, 4'd15);
		send_request(REQ_HEX, -33'sd1, 1'b0, 4'd1);          // negative read as raw pattern
		send_request(REQ_HEX, 33'sh0_FFFF_FFFF, 1'b1, 4'd4);
		send_request(REQ_CLEAR, -33'sd1, 1'b1, 4'd0);        // value and show_zeros set, both ignored
		send_request(REQ_SPARE, 33'sd5, 1'b0, 4'd1);         // unused code acts as clear
	endtask

	// Register extremes, a few requests under each setting
	task automatic test_config_extremes();
		set_display(3'd0, 8'h00);
		repeat (4) send_random_request();
		set_display(3'd7, 8'hFF);
		repeat (4) send_random_request();
		set_display(3'd5, 8'hC3);
		repeat (4) send_random_request();
	endtask

	// No idling on either side, so frames can follow each other with no gap
	task automatic test_back_to_back();
		wait_idle();
		req_gap_max = 0;
		stall_max   = 0;
		repeat (12) send_random_request();
		wait_idle();
		req_gap_max = 14;
		stall_max   = 14;
	endtask

	// Hold off new requests until the block has fully drained, then resume
	task automatic test_drain_pause();
		repeat (4) send_random_request();
		wait_idle();
		repeat (4) send_random_request();
	endtask

	// Random phases, each with its own register setting and idling mix
	task automatic test_random_traffic();
		int phase;
		for (phase = 0; phase < 6; phase++) begin
			set_display(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			req_gap_max = $urandom_range(0, 2) == 0 ? 0 : 14;
			stall_max   = $urandom_range(0, 2) == 0 ? 0 : 14;
			repeat (20) send_random_request();
		end
	endtask

	initial begin
		errors      = 0;
		req_gap_max = 14;
		stall_max   = 14;
		// Registers come out of reset at brightness 2, address 0xC0
		shown_brightness = 3'd2;
		shown_address    = 8'hC0;

		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_DEC;
		req_ch.value       <= '0;
		req_ch.show_zeros  <= 1'b0;
		req_ch.dp_position <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_BRIGHTNESS;
		cfg_ch.data        <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_back_to_back();
		test_drain_pause();
		test_random_traffic();
		wait_idle();

		if (errors == 0)
			$display("[seven_segment_number_frame_builder] OK");
		else
			$display("[seven_segment_number_frame_builder] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
